// ===== design/stq_pkg.sv =====
// Shared constants and types for the sorted timer queue.
`default_nettype none
package stq_pkg;

  // default sizes
  localparam int MAX_TIMERS_C = 16;
  localparam int ID_BITS_C    = 16;
  localparam int TIME_BITS_C  = 32;

  // fixed field widths
  localparam int FUNC_W = 3;
  localparam int AMT_W  = 24;
  localparam int REM_W  = 25;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FN_TICK     = 3'd0;
  localparam func_t FN_ADD_ONCE = 3'd1;
  localparam func_t FN_ADD_PER  = 3'd2;
  localparam func_t FN_REMOVE   = 3'd3;
  localparam func_t FN_QUERY    = 3'd4;

  localparam logic signed [REM_W-1:0] REM_MAX  = 25'sh0FFFFFF;
  localparam logic signed [REM_W-1:0] REM_MIN  = 25'sh1000000;
  localparam logic signed [REM_W-1:0] REM_NONE = 25'sh1FFFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_REINS,
    ST_OP,
    ST_QRY,
    ST_DONE
  } st_t;

  typedef enum logic [1:0] {
    CO_HOLD,
    CO_INS,
    CO_DEL
  } cell_op_t;

  // broadcast control for every cell
  typedef struct packed {
    cell_op_t op;
    logic     by_id;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== design/stq_cell.sv =====
// One queue slot: holds a timer and shifts with its neighbors on insert or delete.
`default_nettype none
module stq_cell
  import stq_pkg::*;
#(
  parameter int ID_BITS   = ID_BITS_C,
  parameter int TIME_BITS = TIME_BITS_C
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cell_ctl_t            ctl,
  input  logic [ID_BITS-1:0]   new_id,
  input  logic [TIME_BITS-1:0] new_dl,
  input  logic [AMT_W-1:0]     new_iv,
  input  logic [ID_BITS-1:0]   key_id,
  input  logic                 left_valid,
  input  logic [ID_BITS-1:0]   left_id,
  input  logic [TIME_BITS-1:0] left_dl,
  input  logic [AMT_W-1:0]     left_iv,
  input  logic                 right_valid,
  input  logic [ID_BITS-1:0]   right_id,
  input  logic [TIME_BITS-1:0] right_dl,
  input  logic [AMT_W-1:0]     right_iv,
  input  logic                 ins_before_in,
  input  logic                 hit_in,
  input  logic [TIME_BITS-1:0] sel_dl_in,
  output logic                 valid,
  output logic [ID_BITS-1:0]   id,
  output logic [TIME_BITS-1:0] dl,
  output logic [AMT_W-1:0]     iv,
  output logic                 ins_before_out,
  output logic                 hit_out,
  output logic [TIME_BITS-1:0] sel_dl_out
);

  logic                 valid_r, valid_nxt;
  logic [ID_BITS-1:0]   id_r, id_nxt;
  logic [TIME_BITS-1:0] dl_r, dl_nxt;
  logic [AMT_W-1:0]     iv_r, iv_nxt;
  logic [TIME_BITS-1:0] diff;
  logic                 match;

  // new deadline at or after ours (signed wrap compare) keeps it behind us;
  // once a slot ahead has taken the insert point, every later slot shifts
  assign diff           = new_dl - dl_r;
  assign ins_before_out = ins_before_in || !(valid_r && !diff[TIME_BITS-1]);
  assign match          = ctl.by_id && valid_r && (id_r == key_id);
  assign hit_out        = hit_in | match;
  assign sel_dl_out     = (match && !hit_in) ? dl_r : sel_dl_in;

  assign valid = valid_r;
  assign id    = id_r;
  assign dl    = dl_r;
  assign iv    = iv_r;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    dl_nxt    = dl_r;
    iv_nxt    = iv_r;
    case (ctl.op)
      CO_INS: begin
        if (ins_before_in) begin
          valid_nxt = left_valid;
          id_nxt    = left_id;
          dl_nxt    = left_dl;
          iv_nxt    = left_iv;
        end else if (ins_before_out) begin
          valid_nxt = 1'b1;
          id_nxt    = new_id;
          dl_nxt    = new_dl;
          iv_nxt    = new_iv;
        end
      end
      CO_DEL: begin
        if (hit_in || match) begin
          valid_nxt = right_valid;
          id_nxt    = right_id;
          dl_nxt    = right_dl;
          iv_nxt    = right_iv;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    dl_r <= dl_nxt;
    iv_r <= iv_nxt;
  end

endmodule
`default_nettype wire

// ===== design/sorted_timer_queue.sv =====
// Top level of the sorted timer queue: command sequencer and the row of slots.
//
// Usage: drive in_func, in_amount_ms and in_timer_id and raise start while
// busy is low; that edge accepts the transaction. func 0 advances the clock
// by in_amount_ms and fires the head timer if due, 1/2 add a one-shot or
// periodic timer, 3 removes by id, 4 queries remaining milliseconds.
// Exactly one result comes back per transaction: out_valid is high for one
// cycle with all out_ fields; fields an operation does not set read 0.
// From accept, add, remove and undefined funcs pass through ST_OP to ST_DONE;
// tick goes through ST_TICK (and ST_REINS when a periodic timer is put back)
// to ST_DONE; query goes through ST_OP and ST_QRY to ST_DONE. busy stays high
// from accept through the result cycle, so the next transaction is taken only
// after the previous result. Each step is one pass of the slot row: every
// slot compares against the broadcast command and shifts from its left or
// right neighbor in the same cycle, so the states do not depend on MAX_TIMERS.
// The receiver cannot stall; the result is gone after its one cycle.
// Reset empties the queue, clears the clock and restarts ids at 1.
`default_nettype none
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int MAX_TIMERS = MAX_TIMERS_C,
  parameter int ID_BITS    = ID_BITS_C,
  parameter int TIME_BITS  = TIME_BITS_C
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [FUNC_W-1:0]       in_func,
  input  logic [AMT_W-1:0]        in_amount_ms,
  input  logic [ID_BITS-1:0]      in_timer_id,
  output logic                    out_valid,
  output logic                    out_fired,
  output logic [ID_BITS-1:0]      out_fired_id,
  output logic [ID_BITS-1:0]      out_new_id,
  output logic                    out_table_full,
  output logic                    out_found,
  output logic signed [REM_W-1:0] out_remaining_ms
);

  // width used to bring 24-bit amounts onto the time scale
  localparam int AXW = (TIME_BITS > AMT_W) ? TIME_BITS : AMT_W;
  // width for the saturating remaining-time compare
  localparam int SW  = (TIME_BITS > REM_W) ? TIME_BITS : REM_W;

  st_t state_r, state_nxt;

  logic [TIME_BITS-1:0]    now_r;
  logic [ID_BITS-1:0]      nid_r;
  func_t                   func_r;
  logic [AMT_W-1:0]        amt_r;
  logic [ID_BITS-1:0]      tid_r;
  logic [ID_BITS-1:0]      hold_id_r;
  logic [TIME_BITS-1:0]    hold_dl_r;
  logic [AMT_W-1:0]        hold_iv_r;
  logic [TIME_BITS-1:0]    qdl_r;
  logic                    fired_r;
  logic [ID_BITS-1:0]      fired_id_r;
  logic [ID_BITS-1:0]      new_id_r;
  logic                    full_r;
  logic                    found_r;
  logic signed [REM_W-1:0] rem_r;

  logic accept;
  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // amount and interval on the time scale
  logic [AXW-1:0]       in_amt_x, amt_x, hold_iv_x;
  logic [TIME_BITS-1:0] in_amt_t, amt_t, hold_iv_t;
  assign in_amt_x  = AXW'(in_amount_ms);
  assign amt_x     = AXW'(amt_r);
  assign hold_iv_x = AXW'(hold_iv_r);
  assign in_amt_t  = in_amt_x[TIME_BITS-1:0];
  assign amt_t     = amt_x[TIME_BITS-1:0];
  assign hold_iv_t = hold_iv_x[TIME_BITS-1:0];

  // slot row signals
  logic                 c_valid [MAX_TIMERS];
  logic [ID_BITS-1:0]   c_id    [MAX_TIMERS];
  logic [TIME_BITS-1:0] c_dl    [MAX_TIMERS];
  logic [AMT_W-1:0]     c_iv    [MAX_TIMERS];
  logic                 ins_ch  [MAX_TIMERS+1];
  logic                 hit_ch  [MAX_TIMERS+1];
  logic [TIME_BITS-1:0] sel_ch  [MAX_TIMERS+1];

  cell_ctl_t            ctl;
  logic                 del_head;
  logic [ID_BITS-1:0]   bc_id;
  logic [TIME_BITS-1:0] bc_dl;
  logic [AMT_W-1:0]     bc_iv;

  // head due test: deadline minus now <= 0
  logic [TIME_BITS-1:0] hd_diff;
  logic                 due;
  assign hd_diff = c_dl[0] - now_r;
  assign due     = c_valid[0] && (hd_diff[TIME_BITS-1] || (hd_diff == '0));

  // next id, wrapping past zero
  logic [ID_BITS-1:0] id_inc, id_calc;
  assign id_inc  = nid_r + ID_BITS'(1);
  assign id_calc = (id_inc == '0) ? ID_BITS'(1) : id_inc;

  logic is_add;
  assign is_add = (func_r == FN_ADD_ONCE) || (func_r == FN_ADD_PER);

  // broadcast entry for an insert: the reload in ST_REINS, otherwise an add
  always_comb begin
    if (state_r == ST_REINS) begin
      bc_id = hold_id_r;
      bc_dl = hold_dl_r + hold_iv_t;
      bc_iv = hold_iv_r;
    end else begin
      bc_id = id_calc;
      bc_dl = now_r + amt_t;
      bc_iv = (func_r == FN_ADD_PER) ? amt_r : '0;
    end
  end

  // chain ends: nothing ahead of slot 0; head delete forces a hit before slot 0
  assign ins_ch[0] = 1'b0;
  assign hit_ch[0] = del_head;
  assign sel_ch[0] = '0;

  for (genvar k = 0; k < MAX_TIMERS; k++) begin : g_slot
    logic                 lv, rv;
    logic [ID_BITS-1:0]   lid, rid;
    logic [TIME_BITS-1:0] ldl, rdl;
    logic [AMT_W-1:0]     liv, riv;

    if (k == 0) begin : g_first
      assign lv  = 1'b0;
      assign lid = '0;
      assign ldl = '0;
      assign liv = '0;
    end else begin : g_mid_l
      assign lv  = c_valid[k-1];
      assign lid = c_id[k-1];
      assign ldl = c_dl[k-1];
      assign liv = c_iv[k-1];
    end

    if (k == MAX_TIMERS-1) begin : g_last
      assign rv  = 1'b0;
      assign rid = '0;
      assign rdl = '0;
      assign riv = '0;
    end else begin : g_mid_r
      assign rv  = c_valid[k+1];
      assign rid = c_id[k+1];
      assign rdl = c_dl[k+1];
      assign riv = c_iv[k+1];
    end

    stq_cell #(
      .ID_BITS   (ID_BITS),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .ctl            (ctl),
      .new_id         (bc_id),
      .new_dl         (bc_dl),
      .new_iv         (bc_iv),
      .key_id         (tid_r),
      .left_valid     (lv),
      .left_id        (lid),
      .left_dl        (ldl),
      .left_iv        (liv),
      .right_valid    (rv),
      .right_id       (rid),
      .right_dl       (rdl),
      .right_iv       (riv),
      .ins_before_in  (ins_ch[k]),
      .hit_in         (hit_ch[k]),
      .sel_dl_in      (sel_ch[k]),
      .valid          (c_valid[k]),
      .id             (c_id[k]),
      .dl             (c_dl[k]),
      .iv             (c_iv[k]),
      .ins_before_out (ins_ch[k+1]),
      .hit_out        (hit_ch[k+1]),
      .sel_dl_out     (sel_ch[k+1])
    );
  end

  logic full_now;
  assign full_now = c_valid[MAX_TIMERS-1];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_func == FN_TICK) ? ST_TICK : ST_OP;
        end
      end
      ST_TICK: begin
        state_nxt = (due && (c_iv[0] != '0)) ? ST_REINS : ST_DONE;
      end
      ST_REINS: state_nxt = ST_DONE;
      ST_OP: begin
        state_nxt = (func_r == FN_QUERY) ? ST_QRY : ST_DONE;
      end
      ST_QRY:  state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // slot-row command per state
  always_comb begin
    ctl.op    = CO_HOLD;
    ctl.by_id = 1'b0;
    del_head  = 1'b0;
    case (state_r)
      ST_TICK: begin
        if (due) begin
          ctl.op   = CO_DEL;
          del_head = 1'b1;
        end
      end
      ST_REINS: ctl.op = CO_INS;
      ST_OP: begin
        case (func_r)
          FN_ADD_ONCE, FN_ADD_PER: begin
            if (!full_now) ctl.op = CO_INS;
          end
          FN_REMOVE: begin
            ctl.op    = CO_DEL;
            ctl.by_id = 1'b1;
          end
          FN_QUERY: ctl.by_id = 1'b1;
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // saturated deadline minus now
  logic [TIME_BITS-1:0]    qdiff;
  logic signed [SW-1:0]    qd_x, rmax_x, rmin_x;
  logic signed [REM_W-1:0] rem_sat;
  assign qdiff  = qdl_r - now_r;
  assign qd_x   = SW'($signed(qdiff));
  assign rmax_x = SW'(REM_MAX);
  assign rmin_x = SW'(REM_MIN);
  assign rem_sat = (qd_x > rmax_x) ? REM_MAX :
                   (qd_x < rmin_x) ? REM_MIN : qd_x[REM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      now_r   <= '0;
      nid_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && (in_func == FN_TICK)) now_r <= now_r + in_amt_t;
      if ((state_r == ST_OP) && is_add && !full_now) nid_r <= id_calc;
    end
  end

  // transaction and result registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_func;
      amt_r      <= in_amount_ms;
      tid_r      <= in_timer_id;
      fired_r    <= 1'b0;
      fired_id_r <= '0;
      new_id_r   <= '0;
      full_r     <= 1'b0;
      found_r    <= 1'b0;
      rem_r      <= '0;
    end
    case (state_r)
      ST_TICK: begin
        if (due) begin
          fired_r    <= 1'b1;
          fired_id_r <= c_id[0];
          hold_id_r  <= c_id[0];
          hold_dl_r  <= c_dl[0];
          hold_iv_r  <= c_iv[0];
        end
      end
      ST_OP: begin
        case (func_r)
          FN_ADD_ONCE, FN_ADD_PER: begin
            if (full_now) full_r <= 1'b1;
            else          new_id_r <= id_calc;
          end
          FN_REMOVE: found_r <= hit_ch[MAX_TIMERS];
          FN_QUERY: begin
            found_r <= hit_ch[MAX_TIMERS];
            qdl_r   <= sel_ch[MAX_TIMERS];
          end
          default: begin
          end
        endcase
      end
      ST_QRY: rem_r <= found_r ? rem_sat : REM_NONE;
      default: begin
      end
    endcase
  end

  assign out_valid        = (state_r == ST_DONE);
  assign out_fired        = fired_r;
  assign out_fired_id     = fired_id_r;
  assign out_new_id       = new_id_r;
  assign out_table_full   = full_r;
  assign out_found        = found_r;
  assign out_remaining_ms = rem_r;

endmodule
`default_nettype wire

// ===== design/stq_checker.sv =====
// Port-level checks for the sorted timer queue, bound to the top level.
`default_nettype none
module stq_checker
  import stq_pkg::*;
#(
  parameter int ID_BITS = ID_BITS_C
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic                    out_valid,
  input logic                    out_fired,
  input logic [ID_BITS-1:0]      out_fired_id,
  input logic [ID_BITS-1:0]      out_new_id,
  input logic                    out_table_full,
  input logic                    out_found,
  input logic signed [REM_W-1:0] out_remaining_ms
);

  // an accepted transaction holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // the result closes the transaction in the cycle after
  a_result_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy ##1 (!busy && !out_valid))
    else $error("result not followed by idle");

  // issued ids are never zero
  a_fired_id: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fired) |-> (out_fired_id != '0))
    else $error("fired timer has id 0");

  // a refused add gives no id
  a_full_noid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_table_full) |-> (out_new_id == '0))
    else $error("id issued on full table");

  // without a hit the remaining time is 0 or the not-found mark
  a_rem_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> ((out_remaining_ms == '0) || (out_remaining_ms == REM_NONE)))
    else $error("remaining time set without a hit");

endmodule

bind sorted_timer_queue stq_checker #(
  .ID_BITS (ID_BITS)
) u_stq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_fired        (out_fired),
  .out_fired_id     (out_fired_id),
  .out_new_id       (out_new_id),
  .out_table_full   (out_table_full),
  .out_found        (out_found),
  .out_remaining_ms (out_remaining_ms)
);
`default_nettype wire

// ===== dv/tb_sorted_timer_queue.sv =====
// Self-checking testbench for sorted_timer_queue: directed and random commands against a predictor.
`timescale 1ns / 100ps
module tb_sorted_timer_queue;
  import stq_pkg::*;

  // Shorthand for the default sizes the DUT is built with.
  localparam int NT = MAX_TIMERS_C;
  localparam int IW = ID_BITS_C;
  localparam int TW = TIME_BITS_C;

  // func codes the block does not define; it must answer them with all zeros
  localparam func_t FN_BAD_FIRST = 3'd5;
  localparam func_t FN_BAD_MID   = 3'd6;
  localparam func_t FN_BAD_LAST  = 3'd7;

  // One command as queued for the driver. pick_live asks the driver to swap
  // in the id of a timer that is in the queue at the moment it is presented.
  typedef struct {
    func_t           func;
    logic [AMT_W-1:0] amount;
    logic [IW-1:0]    tid;
    bit               pick_live;
    int unsigned      gap_pct;   // chance per cycle that the driver holds off
  } command_t;

  // Everything one result transaction carries.
  typedef struct packed {
    logic             fired;
    logic [IW-1:0]    fired_id;
    logic [IW-1:0]    new_id;
    logic             table_full;
    logic             found;
    logic [REM_W-1:0] remaining;
  } outcome_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // All inputs start at known values.
  logic             start        = 1'b0;
  logic [FUNC_W-1:0] in_func     = '0;
  logic [AMT_W-1:0] in_amount_ms = '0;
  logic [IW-1:0]    in_timer_id  = '0;

  logic                    busy;
  logic                    out_valid;
  logic                    out_fired;
  logic [IW-1:0]           out_fired_id;
  logic [IW-1:0]           out_new_id;
  logic                    out_table_full;
  logic                    out_found;
  logic signed [REM_W-1:0] out_remaining_ms;

  always #10 clk = ~clk;

  sorted_timer_queue i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_amount_ms    (in_amount_ms),
    .in_timer_id     (in_timer_id),
    .out_valid       (out_valid),
    .out_fired       (out_fired),
    .out_fired_id    (out_fired_id),
    .out_new_id      (out_new_id),
    .out_table_full  (out_table_full),
    .out_found       (out_found),
    .out_remaining_ms(out_remaining_ms)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the timer table.
  // Live entries always form a prefix of the slots, ordered by deadline; equal
  // deadlines keep arrival order. Time is modulo 2^TW and deadlines compare by
  // their signed difference.
  // ---------------------------------------------------------------------------
  logic [TW-1:0]    clock_ms;
  bit               slot_used   [NT];
  logic [IW-1:0]    slot_id     [NT];
  logic [TW-1:0]    slot_due    [NT];
  logic [AMT_W-1:0] slot_period [NT];
  logic [IW-1:0]    last_issued_id;

  command_t cmd_q[$];       // commands not yet presented
  outcome_t outcome_q[$];   // results owed by the DUT, oldest first
  command_t cur_cmd;        // what is on the input ports right now
  int       total_cmds   = 0;
  int       accepted_cnt = 0;
  int       mismatch_cnt = 0;

  // signed distance a - b on the wrapping millisecond clock
  function automatic logic signed [TW-1:0] span(input logic [TW-1:0] a, input logic [TW-1:0] b);
    return $signed(a - b);
  endfunction

  function automatic int occupancy();
    int n;
    n = 0;
    while (n < NT && slot_used[n]) n++;
    return n;
  endfunction

  // Caller makes sure a slot is free. New entry goes behind every entry whose
  // deadline is not later than its own.
  function automatic void enqueue_timer(input logic [IW-1:0] id, input logic [TW-1:0] due,
                                        input logic [AMT_W-1:0] period);
    int n;
    int pos;
    int k;
    n   = occupancy();
    pos = 0;
    while (pos < n && span(due, slot_due[pos]) >= 0) pos++;
    for (k = n; k > pos; k--) begin
      slot_id[k]     = slot_id[k-1];
      slot_due[k]    = slot_due[k-1];
      slot_period[k] = slot_period[k-1];
      slot_used[k]   = 1'b1;
    end
    slot_id[pos]     = id;
    slot_due[pos]    = due;
    slot_period[pos] = period;
    slot_used[pos]   = 1'b1;
  endfunction

  function automatic void drop_slot(input int pos);
    int n;
    int k;
    n = occupancy();
    for (k = pos; k + 1 < n; k++) begin
      slot_id[k]     = slot_id[k+1];
      slot_due[k]    = slot_due[k+1];
      slot_period[k] = slot_period[k+1];
    end
    if (n > 0) slot_used[n-1] = 1'b0;
  endfunction

  // first match in queue order, -1 when absent
  function automatic int find_slot(input logic [IW-1:0] id);
    int k;
    for (k = 0; k < NT && slot_used[k]; k++)
      if (slot_id[k] == id) return k;
    return -1;
  endfunction

  // Applies one accepted command to the shadow table and returns the result
  // the DUT owes for it.
  function automatic outcome_t predict_outcome(input command_t c);
    outcome_t            r;
    int                  p;
    logic [IW-1:0]       id;
    logic [TW-1:0]       due;
    logic [AMT_W-1:0]    per;
    logic signed [TW-1:0] d;
    r = '0;
    case (c.func)
      FN_TICK: begin
        clock_ms = clock_ms + c.amount;
        // only the head can fire, and only one per tick
        if (slot_used[0] && span(slot_due[0], clock_ms) <= 0) begin
          id  = slot_id[0];
          due = slot_due[0];
          per = slot_period[0];
          r.fired    = 1'b1;
          r.fired_id = id;
          drop_slot(0);
          // periodic reload is relative to the old deadline, not to now
          if (per != '0) enqueue_timer(id, due + per, per);
        end
      end
      FN_ADD_ONCE, FN_ADD_PER: begin
        if (occupancy() >= NT) begin
          r.table_full = 1'b1;
        end else begin
          id = last_issued_id + 1'b1;
          if (id == '0) id = IW'(1);   // ids skip zero on wrap
          last_issued_id = id;
          r.new_id       = id;
          per = (c.func == FN_ADD_PER) ? c.amount : '0;
          enqueue_timer(id, clock_ms + c.amount, per);
        end
      end
      FN_REMOVE: begin
        p = find_slot(c.tid);
        if (p >= 0) begin
          r.found = 1'b1;
          drop_slot(p);
        end
      end
      FN_QUERY: begin
        p = find_slot(c.tid);
        if (p >= 0) begin
          r.found = 1'b1;
          d = span(slot_due[p], clock_ms);
          if (d > REM_MAX)      r.remaining = REM_MAX;
          else if (d < REM_MIN) r.remaining = REM_MIN;
          else                  r.remaining = d[REM_W-1:0];
        end else begin
          r.remaining = REM_NONE;
        end
      end
      default: ;   // undefined func: nothing changes, all fields zero
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_cmd(input func_t f, input logic [AMT_W-1:0] a,
                                   input logic [IW-1:0] t, input int unsigned gap);
    command_t c;
    c.func      = f;
    c.amount    = a;
    c.tid       = t;
    c.pick_live = 1'b0;
    c.gap_pct   = gap;
    cmd_q.push_back(c);
  endfunction

  // Mostly short delays so deadlines land close together and the table
  // fills; now and then zero, fully random or the largest value.
  function automatic logic [AMT_W-1:0] pick_delay();
    case ($urandom_range(0, 19))
      0:       return '0;
      1, 2, 3: return AMT_W'($urandom);
      4, 5:    return '1;
      default: return AMT_W'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic command_t random_command(input int unsigned gap);
    command_t    c;
    int unsigned r;
    c.func      = FN_TICK;
    c.amount    = AMT_W'($urandom);
    c.tid       = IW'($urandom);
    c.pick_live = 1'b0;
    c.gap_pct   = gap;
    r = $urandom_range(0, 99);
    if (r < 38) begin
      // adds outnumber ticks so the table regularly runs full
      c.func   = $urandom_range(0, 1) ? FN_ADD_PER : FN_ADD_ONCE;
      c.amount = pick_delay();
    end else if (r < 65) begin
      c.func   = FN_TICK;
      c.amount = pick_delay();
    end else if (r < 95) begin
      c.func      = (r < 77) ? FN_REMOVE : FN_QUERY;
      c.pick_live = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       c.tid = '0;
        1:       c.tid = '1;
        default: ;
      endcase
    end else begin
      c.func = func_t'($urandom_range(FN_BAD_FIRST, FN_BAD_LAST));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the next pending command and keeps start up until the
  // DUT takes it. The shadow table is updated at the accepting edge, so a
  // live id picked for the next command already reflects every accepted one.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_proc
    command_t nxt;
    int       n;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        outcome_q.push_back(predict_outcome(cur_cmd));
        accepted_cnt++;
      end
      // free to change the ports unless a transaction is still waiting
      if (!start || !busy) begin
        if (cmd_q.size() != 0 && $urandom_range(0, 99) >= cmd_q[0].gap_pct) begin
          nxt = cmd_q.pop_front();
          n   = occupancy();
          if (nxt.pick_live && n != 0) nxt.tid = slot_id[$urandom_range(0, n - 1)];
          cur_cmd      = nxt;
          start        <= 1'b1;
          in_func      <= nxt.func;
          in_amount_ms <= nxt.amount;
          in_timer_id  <= nxt.tid;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      mismatch_cnt++;
      $display("%0t: %s expected %h, got %h", $time, fname, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor_proc
    outcome_t want;
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: result strobe expected none, got one with no transaction pending",
                 $time);
      end else begin
        want = outcome_q.pop_front();
        check_field("fired",        32'(want.fired),      32'(out_fired));
        check_field("fired_id",     32'(want.fired_id),   32'(out_fired_id));
        check_field("new_id",       32'(want.new_id),     32'(out_new_id));
        check_field("table_full",   32'(want.table_full), 32'(out_table_full));
        check_field("found",        32'(want.found),      32'(out_found));
        check_field("remaining_ms", 32'(want.remaining),
                    32'($unsigned(out_remaining_ms)));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    clock_ms       = '0;
    last_issued_id = '0;
    for (k = 0; k < NT; k++) slot_used[k] = 1'b0;

    // Directed: empty-table misses, zero and max deltas, equal deadlines,
    // zero-interval periodic, periodic reload, undefined funcs.
    push_cmd(FN_QUERY,    '0,     '0,     21);  // miss on empty table gives -1
    push_cmd(FN_REMOVE,   '1,     '1,     21);
    push_cmd(FN_TICK,     '0,     '1,     21);  // bare poll, nothing to fire
    push_cmd(FN_TICK,     '1,     '0,     21);
    push_cmd(FN_ADD_ONCE, '0,     '1,     21);  // id 1, due immediately
    push_cmd(FN_ADD_PER,  '0,     '0,     21);  // id 2, zero interval: one-shot
    push_cmd(FN_ADD_PER,  24'd3,  '0,     21);  // id 3, reloads every 3 ms
    push_cmd(FN_QUERY,    '1,     16'd1,  21);  // 0 remaining
    push_cmd(FN_TICK,     '0,     '0,     21);  // fires 1 (added first)
    push_cmd(FN_TICK,     '0,     '0,     21);  // fires 2, not put back
    push_cmd(FN_QUERY,    '0,     16'd2,  21);
    push_cmd(FN_QUERY,    '0,     16'd3,  21);
    push_cmd(FN_TICK,     24'd5,  '1,     21);  // 3 overdue by 2, reloads 1 ms out
    push_cmd(FN_QUERY,    '0,     16'd3,  21);
    push_cmd(FN_BAD_FIRST, '1,    '1,     21);
    push_cmd(FN_BAD_MID,  AMT_W'($urandom), IW'($urandom), 21);
    push_cmd(FN_BAD_LAST, '0,     '0,     21);
    push_cmd(FN_ADD_ONCE, '1,     '0,     21);  // id 4, farthest deadline
    push_cmd(FN_ADD_PER,  '1,     '0,     21);  // id 5, same deadline, behind 4
    push_cmd(FN_REMOVE,   '1,     16'd3,  21);
    push_cmd(FN_REMOVE,   '0,     16'd3,  21);  // already gone
    push_cmd(FN_QUERY,    '0,     16'd5,  21);  // full range remaining

    // Run the clock up toward its wrap with max ticks; the random phases
    // that follow carry it across.
    for (k = 0; k < 256; k++) begin
      if ($urandom_range(0, 99) < 95) push_cmd(FN_TICK, '1, IW'($urandom), 21);
      else                            cmd_q.push_back(random_command(21));
    end

    // Random phases: sender stalls lightly, then heavily, then not at all.
    for (k = 0; k < 260; k++) cmd_q.push_back(random_command(21));
    for (k = 0; k < 260; k++) cmd_q.push_back(random_command(85));
    for (k = 0; k < 260; k++) cmd_q.push_back(random_command(0));
    total_cmds = cmd_q.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Sample on the falling edge to stay clear of the driver and monitor.
    while (accepted_cnt < total_cmds) @(negedge clk);
    while (outcome_q.size() != 0) @(negedge clk);
    // catch any stray strobe after the last result
    repeat (8) @(negedge clk);

    if (mismatch_cnt == 0) begin
      $display("sorted_timer_queue: match");
    end else begin
      $display("sorted_timer_queue: mismatch");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin : watchdog
    #100_000_000;
    $display("sorted_timer_queue: mismatch");
    $finish;
  end

endmodule

// ===== sorted_timer_queue.f =====
design/stq_pkg.sv
design/stq_cell.sv
design/sorted_timer_queue.sv
design/stq_checker.sv
dv/tb_sorted_timer_queue.sv
